@@ src/sci_pkg.sv @@
// shared constants for the segment corner intersection pipeline
// angle table, latencies and field widths; no dependencies
`default_nettype none
package sci_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int IN_W = 12;
  localparam int CFG_W = 13;
  localparam int XY_W = 32;
  localparam int ANG_W = 12;
  localparam logic [CFG_W-1:0] MIN_LENGTH_RESET = 13'd300;

  localparam int ANGLE_ITERS = 16;
  localparam int ZW = 25;
  localparam int RIGHT_ANGLE_16THS = 1440;
  localparam int HALF_TURN_DEG = 180;
  localparam int ATAN_TAB [ANGLE_ITERS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  // quotient bits below the saturation point
  localparam int DIV_STEPS = 31;
  localparam int DIV_LAT = DIV_STEPS + 2;
  localparam int ANG_LAT = ANGLE_ITERS + 1;

endpackage
`default_nettype wire

@@ src/sci_div.sv @@
// pipelined rounding divider: round(num * 16 / den), saturated to 32 bits
// uses sci_pkg; one quotient bit per stage
`default_nettype none
module sci_div
  import sci_pkg::*;
#(
  parameter int NUM_W = 40,
  parameter int DEN_W = 27
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic        [DEN_W-1:0] den,
  output logic             [XY_W-1:0]  result
);

  localparam int AW = NUM_W + 6;
  localparam int BW = DEN_W + 1;
  localparam int CW = ((AW > BW + DIV_STEPS) ? AW : BW + DIV_STEPS) + 1;

  logic [NUM_W-1:0]     mag;
  logic [CW-1:0]        a_full;
  logic [CW-1:0]        b_full;

  logic [CW-1:0]        rem  [0:DIV_STEPS];
  logic [CW-1:0]        bden [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] quo  [0:DIV_STEPS];
  logic                 neg  [0:DIV_STEPS];
  logic                 big  [0:DIV_STEPS];

  assign mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign a_full = CW'({mag, 5'b0}) + CW'(den);
  assign b_full = CW'({den, 1'b0});

  // prep: numerator, divisor and the saturation check
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= a_full;
      bden[0] <= b_full;
      quo[0]  <= '0;
      neg[0]  <= num[NUM_W-1];
      big[0]  <= a_full >= (b_full << DIV_STEPS);
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [CW-1:0] sh;
    assign sh = bden[k] << (DIV_STEPS - 1 - k);
    always_ff @(posedge clk) begin
      if (en) begin
        bden[k+1] <= bden[k];
        neg[k+1]  <= neg[k];
        big[k+1]  <= big[k];
        if (rem[k] >= sh) begin
          rem[k+1] <= rem[k] - sh;
          quo[k+1] <= quo[k] | (DIV_STEPS'(1) << (DIV_STEPS - 1 - k));
        end else begin
          rem[k+1] <= rem[k];
          quo[k+1] <= quo[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (big[DIV_STEPS]) begin
        result <= neg[DIV_STEPS] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (neg[DIV_STEPS]) begin
        result <= XY_W'(0) - XY_W'(quo[DIV_STEPS]);
      end else begin
        result <= XY_W'(quo[DIV_STEPS]);
      end
    end
  end

endmodule
`default_nettype wire

@@ src/sci_cordic.sv @@
// pipelined vectoring cordic giving a slope angle in sixteenths of a degree
// uses sci_pkg for the arctangent table
`default_nettype none
module sci_cordic
  import sci_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [COORD_BITS-1:0]   dx,
  input  wire logic signed [COORD_BITS:0] dy,
  output logic signed [ANG_W-1:0]      angle
);

  localparam int AW = COORD_BITS + 19;

  logic signed [AW-1:0] x_in;
  logic signed [AW-1:0] y_in;
  logic signed [AW-1:0] xr [0:ANGLE_ITERS-1];
  logic signed [AW-1:0] yr [0:ANGLE_ITERS-1];
  logic signed [ZW-1:0] zr [0:ANGLE_ITERS-1];
  logic                 vert [0:ANGLE_ITERS-1];

  logic signed [ZW-1:0] z_rnd;
  logic signed [ZW-1:0] z_sh;

  assign x_in = $signed({3'b0, dx, 16'b0});
  assign y_in = AW'(dy) <<< 16;

  for (genvar k = 0; k < ANGLE_ITERS; k++) begin : g_iter
    logic signed [AW-1:0] xc;
    logic signed [AW-1:0] yc;
    logic signed [ZW-1:0] zc;
    logic                 vc;
    if (k == 0) begin : g_first
      assign xc = x_in;
      assign yc = y_in;
      assign zc = '0;
      assign vc = (dx == '0);
    end else begin : g_next
      assign xc = xr[k-1];
      assign yc = yr[k-1];
      assign zc = zr[k-1];
      assign vc = vert[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        vert[k] <= vc;
        if (yc >= 0) begin
          xr[k] <= xc + (yc >>> k);
          yr[k] <= yc - (xc >>> k);
          zr[k] <= zc + ZW'(ATAN_TAB[k]);
        end else begin
          xr[k] <= xc - (yc >>> k);
          yr[k] <= yc + (xc >>> k);
          zr[k] <= zc - ZW'(ATAN_TAB[k]);
        end
      end
    end
  end

  assign z_rnd = zr[ANGLE_ITERS-1] + ZW'(2048);
  assign z_sh  = z_rnd >>> 12;

  always_ff @(posedge clk) begin
    if (en) begin
      if (vert[ANGLE_ITERS-1] || z_sh > ZW'(RIGHT_ANGLE_16THS)) begin
        angle <= ANG_W'(RIGHT_ANGLE_16THS);
      end else if (z_sh < -ZW'(RIGHT_ANGLE_16THS)) begin
        angle <= -ANG_W'(RIGHT_ANGLE_16THS);
      end else begin
        angle <= ANG_W'(z_sh);
      end
    end
  end

endmodule
`default_nettype wire

@@ src/segment_corner_intersection.sv @@
// top level of the segment corner intersection pipeline
// uses sci_pkg, sci_div and sci_cordic
//
// channel   | handshake              | payload
// input     | in_valid / in_stall    | first_*, second_* endpoints
// result    | out_valid / out_stall  | is_corner, cross_x, cross_y, corner_angle
// config    | min_length_we          | min_length_wdata
//
// one item per cycle unless a held result is stalled; from accept to result each item
// passes 7 geometry stages, the 33-stage divider and one output register
// the divider sets the depth: one quotient bit per stage
// rst clears the valid bits and sets min_length to 300
// a stall on the result side while a result is held freezes the whole pipeline; nothing is dropped
`default_nettype none
module segment_corner_intersection
  import sci_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [IN_W-1:0]  first_x_start,
  input  wire logic [IN_W-1:0]  first_y_start,
  input  wire logic [IN_W-1:0]  first_x_end,
  input  wire logic [IN_W-1:0]  first_y_end,
  input  wire logic [IN_W-1:0]  second_x_start,
  input  wire logic [IN_W-1:0]  second_y_start,
  input  wire logic [IN_W-1:0]  second_x_end,
  input  wire logic [IN_W-1:0]  second_y_end,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  is_corner,
  output logic [XY_W-1:0]       cross_x,
  output logic [XY_W-1:0]       cross_y,
  output logic [ANG_W-1:0]      corner_angle,
  input  wire logic             min_length_we,
  input  wire logic [CFG_W-1:0] min_length_wdata
);

  localparam int N  = COORD_BITS;
  localparam int LW = (2*N + 1 > 2*CFG_W) ? 2*N + 1 : 2*CFG_W;  // squared lengths
  localparam int DW = 2*N + 3;                                  // determinant
  localparam int NW = 3*N + 4;                                  // numerators
  localparam int PW = 3*N + 5;                                  // span bounds times d
  localparam int ANG_DLY = DIV_LAT - ANG_LAT;

  logic [CFG_W-1:0] min_length;
  logic adv;

  // whole pipeline moves unless the output register is full and stalled
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
    end else if (min_length_we) begin
      min_length <= min_length_wdata;
    end
  end

  // valid bits of the geometry stages
  logic [7:1] v;
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[6:1], in_valid};
    end
  end

  // ---- stage 1: order endpoints leftmost first, deltas
  logic [N-1:0] c0, c1, c2, c3, c4, c5, c6, c7;
  assign c0 = N'(first_x_start);
  assign c1 = N'(first_y_start);
  assign c2 = N'(first_x_end);
  assign c3 = N'(first_y_end);
  assign c4 = N'(second_x_start);
  assign c5 = N'(second_y_start);
  assign c6 = N'(second_x_end);
  assign c7 = N'(second_y_end);

  logic [N-1:0] o_x1, o_y1, o_x2, o_y2, o_x3, o_y3, o_x4, o_y4;
  logic signed [N:0] o_dy1, o_dy2;
  always_comb begin
    if (c0 > c2) begin
      o_x1 = c2; o_y1 = c3; o_x2 = c0; o_y2 = c1;
    end else begin
      o_x1 = c0; o_y1 = c1; o_x2 = c2; o_y2 = c3;
    end
    if (c4 > c6) begin
      o_x3 = c6; o_y3 = c7; o_x4 = c4; o_y4 = c5;
    end else begin
      o_x3 = c4; o_y3 = c5; o_x4 = c6; o_y4 = c7;
    end
    o_dy1 = $signed({1'b0, o_y2}) - $signed({1'b0, o_y1});
    o_dy2 = $signed({1'b0, o_y4}) - $signed({1'b0, o_y3});
  end

  logic [N-1:0] s1_x1, s1_y1, s1_x2, s1_y2, s1_x3, s1_y3, s1_x4, s1_y4;
  logic [N-1:0] s1_dx1, s1_dx2, s1_ady1, s1_ady2;
  logic signed [N:0] s1_dy1, s1_dy2;
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x1 <= o_x1; s1_y1 <= o_y1; s1_x2 <= o_x2; s1_y2 <= o_y2;
      s1_x3 <= o_x3; s1_y3 <= o_y3; s1_x4 <= o_x4; s1_y4 <= o_y4;
      s1_dx1 <= o_x2 - o_x1;
      s1_dx2 <= o_x4 - o_x3;
      s1_dy1 <= o_dy1;
      s1_dy2 <= o_dy2;
      s1_ady1 <= o_dy1[N] ? N'(-o_dy1) : N'(o_dy1);
      s1_ady2 <= o_dy2[N] ? N'(-o_dy2) : N'(o_dy2);
    end
  end

  // ---- stage 2: squared lengths and the determinant cross products
  logic [LW-1:0] s2_len1, s2_len2, s2_thr;
  logic signed [2*N+1:0] s2_d_a, s2_d_b;
  logic [2*N-1:0] s2_pre_a, s2_pre_b, s2_post_a, s2_post_b;
  logic [N-1:0] s2_x1, s2_y1, s2_x2, s2_y2, s2_x3, s2_y3, s2_x4, s2_y4;
  logic [N-1:0] s2_dx1, s2_dx2;
  logic signed [N:0] s2_dy1, s2_dy2;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_len1 <= LW'(s1_dx1) * LW'(s1_dx1) + LW'(s1_ady1) * LW'(s1_ady1);
      s2_len2 <= LW'(s1_dx2) * LW'(s1_dx2) + LW'(s1_ady2) * LW'(s1_ady2);
      s2_thr  <= LW'(min_length) * LW'(min_length);
      s2_d_a  <= $signed({1'b0, s1_dx1}) * s1_dy2;
      s2_d_b  <= s1_dy1 * $signed({1'b0, s1_dx2});
      s2_pre_a  <= (2*N)'(s1_x1) * (2*N)'(s1_y2);
      s2_pre_b  <= (2*N)'(s1_y1) * (2*N)'(s1_x2);
      s2_post_a <= (2*N)'(s1_x3) * (2*N)'(s1_y4);
      s2_post_b <= (2*N)'(s1_y3) * (2*N)'(s1_x4);
      s2_x1 <= s1_x1; s2_y1 <= s1_y1; s2_x2 <= s1_x2; s2_y2 <= s1_y2;
      s2_x3 <= s1_x3; s2_y3 <= s1_y3; s2_x4 <= s1_x4; s2_y4 <= s1_y4;
      s2_dx1 <= s1_dx1; s2_dx2 <= s1_dx2; s2_dy1 <= s1_dy1; s2_dy2 <= s1_dy2;
    end
  end

  // ---- stage 3: length check, determinant, line constants
  logic s3_short;
  logic signed [DW-1:0] s3_d;
  logic signed [2*N:0] s3_pre, s3_post;
  logic [N-1:0] s3_x1, s3_y1, s3_x2, s3_y2, s3_x3, s3_y3, s3_x4, s3_y4;
  logic [N-1:0] s3_dx1, s3_dx2;
  logic signed [N:0] s3_dy1, s3_dy2;
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_short <= (s2_len1 < s2_thr) || (s2_len2 < s2_thr);
      s3_d     <= DW'(s2_d_a) - DW'(s2_d_b);
      s3_pre   <= $signed({1'b0, s2_pre_a}) - $signed({1'b0, s2_pre_b});
      s3_post  <= $signed({1'b0, s2_post_a}) - $signed({1'b0, s2_post_b});
      s3_x1 <= s2_x1; s3_y1 <= s2_y1; s3_x2 <= s2_x2; s3_y2 <= s2_y2;
      s3_x3 <= s2_x3; s3_y3 <= s2_y3; s3_x4 <= s2_x4; s3_y4 <= s2_y4;
      s3_dx1 <= s2_dx1; s3_dx2 <= s2_dx2; s3_dy1 <= s2_dy1; s3_dy2 <= s2_dy2;
    end
  end

  // ---- stage 4: numerator products
  // nx = dx1*post - pre*dx2, ny = dy1*post - pre*dy2
  logic signed [NW-1:0] s4_nx_a, s4_nx_b, s4_ny_a, s4_ny_b;
  logic s4_short;
  logic signed [DW-1:0] s4_d;
  logic [N-1:0] s4_x1, s4_y1, s4_x2, s4_y2, s4_x3, s4_y3, s4_x4, s4_y4;
  logic [N-1:0] s4_dx1, s4_dx2;
  logic signed [N:0] s4_dy1, s4_dy2;
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_nx_a <= $signed({1'b0, s3_dx1}) * s3_post;
      s4_nx_b <= s3_pre * $signed({1'b0, s3_dx2});
      s4_ny_a <= s3_dy1 * s3_post;
      s4_ny_b <= s3_pre * s3_dy2;
      s4_short <= s3_short;
      s4_d <= s3_d;
      s4_x1 <= s3_x1; s4_y1 <= s3_y1; s4_x2 <= s3_x2; s4_y2 <= s3_y2;
      s4_x3 <= s3_x3; s4_y3 <= s3_y3; s4_x4 <= s3_x4; s4_y4 <= s3_y4;
      s4_dx1 <= s3_dx1; s4_dx2 <= s3_dx2; s4_dy1 <= s3_dy1; s4_dy2 <= s3_dy2;
    end
  end

  // ---- stage 5: numerators, sign normalized so the denominator is positive
  logic signed [NW-1:0] nx_t, ny_t;
  assign nx_t = s4_nx_a - s4_nx_b;
  assign ny_t = s4_ny_a - s4_ny_b;

  logic signed [NW-1:0] s5_nx, s5_ny;
  logic signed [DW-1:0] s5_d;
  logic s5_reject;
  logic [N-1:0] s5_x1, s5_y1, s5_x2, s5_y2, s5_x3, s5_y3, s5_x4, s5_y4;
  logic [N-1:0] s5_dx1, s5_dx2;
  logic signed [N:0] s5_dy1, s5_dy2;
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_nx <= s4_d[DW-1] ? -nx_t : nx_t;
      s5_ny <= s4_d[DW-1] ? -ny_t : ny_t;
      s5_d  <= s4_d[DW-1] ? -s4_d : s4_d;
      // short segments and parallel lines
      s5_reject <= s4_short || (s4_d == '0);
      s5_x1 <= s4_x1; s5_y1 <= s4_y1; s5_x2 <= s4_x2; s5_y2 <= s4_y2;
      s5_x3 <= s4_x3; s5_y3 <= s4_y3; s5_x4 <= s4_x4; s5_y4 <= s4_y4;
      s5_dx1 <= s4_dx1; s5_dx2 <= s4_dx2; s5_dy1 <= s4_dy1; s5_dy2 <= s4_dy2;
    end
  end

  // ---- stage 6: segment spans scaled by the denominator
  logic signed [PW-1:0] s6_bx1, s6_bx2, s6_by1, s6_by2, s6_bx3, s6_bx4, s6_by3, s6_by4;
  logic signed [NW-1:0] s6_nx, s6_ny;
  logic signed [DW-1:0] s6_d;
  logic s6_reject;
  logic [N-1:0] s6_dx1, s6_dx2;
  logic signed [N:0] s6_dy1, s6_dy2;
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_bx1 <= $signed({1'b0, s5_x1}) * s5_d;
      s6_bx2 <= $signed({1'b0, s5_x2}) * s5_d;
      s6_by1 <= $signed({1'b0, s5_y1}) * s5_d;
      s6_by2 <= $signed({1'b0, s5_y2}) * s5_d;
      s6_bx3 <= $signed({1'b0, s5_x3}) * s5_d;
      s6_bx4 <= $signed({1'b0, s5_x4}) * s5_d;
      s6_by3 <= $signed({1'b0, s5_y3}) * s5_d;
      s6_by4 <= $signed({1'b0, s5_y4}) * s5_d;
      s6_nx <= s5_nx; s6_ny <= s5_ny; s6_d <= s5_d; s6_reject <= s5_reject;
      s6_dx1 <= s5_dx1; s6_dx2 <= s5_dx2; s6_dy1 <= s5_dy1; s6_dy2 <= s5_dy2;
    end
  end

  // ---- stage 7: t-junction test, strictly inside a span rejects
  // the y test is start < y < end in that order only
  logic signed [PW-1:0] nxe, nye;
  logic t_junc;
  assign nxe = PW'(s6_nx);
  assign nye = PW'(s6_ny);
  assign t_junc = (nxe > s6_bx1 && nxe < s6_bx2) || (nye > s6_by1 && nye < s6_by2) ||
                  (nxe > s6_bx3 && nxe < s6_bx4) || (nye > s6_by3 && nye < s6_by4);

  logic s7_corner;
  logic signed [NW-1:0] s7_nx, s7_ny;
  logic signed [DW-1:0] s7_d;
  logic [N-1:0] s7_dx1, s7_dx2;
  logic signed [N:0] s7_dy1, s7_dy2;
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_corner <= !s6_reject && !t_junc;
      s7_nx <= s6_nx; s7_ny <= s6_ny; s7_d <= s6_d;
      s7_dx1 <= s6_dx1; s7_dx2 <= s6_dx2; s7_dy1 <= s6_dy1; s7_dy2 <= s6_dy2;
    end
  end

  // ---- back end: two dividers and two angle units run side by side
  logic [XY_W-1:0] qx, qy;
  logic signed [ANG_W-1:0] a1, a2;

  sci_div #(.NUM_W(NW), .DEN_W(DW)) u_div_x (
    .clk(clk), .en(adv), .num(s7_nx), .den(DW'(s7_d)), .result(qx)
  );
  sci_div #(.NUM_W(NW), .DEN_W(DW)) u_div_y (
    .clk(clk), .en(adv), .num(s7_ny), .den(DW'(s7_d)), .result(qy)
  );
  sci_cordic #(.COORD_BITS(N)) u_ang_1 (
    .clk(clk), .en(adv), .dx(s7_dx1), .dy(s7_dy1), .angle(a1)
  );
  sci_cordic #(.COORD_BITS(N)) u_ang_2 (
    .clk(clk), .en(adv), .dx(s7_dx2), .dy(s7_dy2), .angle(a2)
  );

  // angle difference, then delayed to line up with the quotients
  logic signed [ANG_W:0] adiff;
  logic [ANG_W:0] aabs;
  logic [ANG_W-1:0] ang_dly [0:ANG_DLY-1];
  assign adiff = (ANG_W+1)'(a2) - (ANG_W+1)'(a1);
  assign aabs  = adiff[ANG_W] ? (ANG_W+1)'(-adiff) : (ANG_W+1)'(adiff);

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_dly[0] <= (aabs > (ANG_W+1)'(16 * HALF_TURN_DEG)) ?
                    ANG_W'(16 * HALF_TURN_DEG) : ANG_W'(aabs);
      for (int i = 1; i < ANG_DLY; i++) begin
        ang_dly[i] <= ang_dly[i-1];
      end
    end
  end

  // corner flag and valid bit ride along with the divider
  logic [DIV_LAT-1:0] vd;
  logic [DIV_LAT-1:0] cd;
  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else if (adv) begin
      vd <= {vd[DIV_LAT-2:0], v[7]};
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      cd <= {cd[DIV_LAT-2:0], s7_corner};
    end
  end

  // ---- output register, zero payload when no corner
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vd[DIV_LAT-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      is_corner    <= cd[DIV_LAT-1];
      cross_x      <= cd[DIV_LAT-1] ? qx : '0;
      cross_y      <= cd[DIV_LAT-1] ? qy : '0;
      corner_angle <= cd[DIV_LAT-1] ? ang_dly[ANG_DLY-1] : '0;
    end
  end

`ifndef SYNTHESIS
  a_no_corner_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_corner |-> cross_x == '0 && cross_y == '0 && corner_angle == '0)
    else $error("non-corner item carries a payload");

  a_angle_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> corner_angle <= ANG_W'(16 * HALF_TURN_DEG))
    else $error("corner angle beyond half turn");

  a_valid_source : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vd[DIV_LAT-1]) && $past(adv))
    else $error("result appeared without an item in the last stage");
`endif

endmodule
`default_nettype wire

@@ test/segment_corner_intersection_test.sv @@
// self-checking testbench for the segment corner intersection block
// depends on sci_pkg and segment_corner_intersection; predicts each result in a class
`default_nettype none
module segment_corner_intersection_test;
  import sci_pkg::*;

  // one segment pair as driven on the input ports
  typedef struct {
    logic [IN_W-1:0] c [8];
  } seg_pair_t;

  typedef struct {
    logic             corner;
    logic [XY_W-1:0]  px;
    logic [XY_W-1:0]  py;
    logic [ANG_W-1:0] ang;
  } corner_t;

  // predictor and store of expected corners
  class corner_board;
    logic [CFG_W-1:0] min_len;
    corner_t pending [$];
    int errors;
    int corners_seen;
    int checked;

    function new();
      min_len = MIN_LENGTH_RESET;
      errors = 0;
      corners_seen = 0;
      checked = 0;
    endfunction

    static function longint shr(longint v, int s);
      return v >>> s;
    endfunction

    // slope angle in sixteenths of a degree, dx >= 0
    static function longint slope_16ths(longint dx, longint dy);
      longint x, y, z, nx;
      z = 0;
      if (dx == 0) return RIGHT_ANGLE_16THS;
      x = dx * 65536;
      y = dy * 65536;
      for (int i = 0; i < ANGLE_ITERS; i++) begin
        if (y >= 0) begin
          nx = x + shr(y, i);
          y = y - shr(x, i);
          z += ATAN_TAB[i];
        end else begin
          nx = x - shr(y, i);
          y = y + shr(x, i);
          z -= ATAN_TAB[i];
        end
        x = nx;
      end
      z = shr(z + 2048, 12);
      if (z > RIGHT_ANGLE_16THS) z = RIGHT_ANGLE_16THS;
      if (z < -RIGHT_ANGLE_16THS) z = -RIGHT_ANGLE_16THS;
      return z;
    endfunction

    // rounded num*16/den, saturated to 32 bit signed
    static function logic [XY_W-1:0] to_fix4(longint num, longint den);
      logic [127:0] mag, q;
      mag = (num < 0) ? 128'(-num) : 128'(num);
      q = (mag * 32 + 128'(den)) / (128'(den) * 2);
      if (num < 0) begin
        if (q > 128'h8000_0000) q = 128'h8000_0000;
        return XY_W'(-q);
      end
      if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
      return XY_W'(q);
    endfunction

    static function bit strictly_in(longint n, longint a, longint b, longint d);
      return n > a * d && n < b * d;
    endfunction

    function corner_t predict(seg_pair_t p);
      longint c [8];
      longint x1, y1, x2, y2, x3, y3, x4, y4, d, pre, post, nx, ny, ang, thr;
      corner_t r;
      r = '{1'b0, '0, '0, '0};
      for (int i = 0; i < 8; i++) c[i] = longint'(p.c[i]);
      // leftmost endpoint first, no swap on equal x
      if (c[0] > c[2]) begin
        x1 = c[2]; y1 = c[3]; x2 = c[0]; y2 = c[1];
      end else begin
        x1 = c[0]; y1 = c[1]; x2 = c[2]; y2 = c[3];
      end
      if (c[4] > c[6]) begin
        x3 = c[6]; y3 = c[7]; x4 = c[4]; y4 = c[5];
      end else begin
        x3 = c[4]; y3 = c[5]; x4 = c[6]; y4 = c[7];
      end
      thr = longint'(min_len) * longint'(min_len);
      if ((x2-x1)*(x2-x1) + (y2-y1)*(y2-y1) < thr) return r;
      if ((x4-x3)*(x4-x3) + (y4-y3)*(y4-y3) < thr) return r;
      d = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
      if (d == 0) return r;
      pre = x1 * y2 - y1 * x2;
      post = x3 * y4 - y3 * x4;
      nx = pre * (x3 - x4) - (x1 - x2) * post;
      ny = pre * (y3 - y4) - (y1 - y2) * post;
      if (d < 0) begin
        d = -d; nx = -nx; ny = -ny;
      end
      // t-junction: strictly inside a span
      if (strictly_in(nx, x1, x2, d) || strictly_in(ny, y1, y2, d) ||
          strictly_in(nx, x3, x4, d) || strictly_in(ny, y3, y4, d)) return r;
      ang = slope_16ths(x4 - x3, y4 - y3) - slope_16ths(x2 - x1, y2 - y1);
      if (ang < 0) ang = -ang;
      if (ang > 16 * HALF_TURN_DEG) ang = 16 * HALF_TURN_DEG;
      r.corner = 1'b1;
      r.px = to_fix4(nx, d);
      r.py = to_fix4(ny, d);
      r.ang = ANG_W'(ang);
      return r;
    endfunction

    function void note_input(seg_pair_t p);
      pending.push_back(predict(p));
    endfunction

    function void check_result(corner_t got);
      corner_t want;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.corner) corners_seen++;
      if (got.corner !== want.corner) begin
        $error("is_corner expected %0d actual %0d", want.corner, got.corner);
        errors++;
      end
      if (got.px !== want.px) begin
        $error("cross_x expected %0d actual %0d", $signed(want.px), $signed(got.px));
        errors++;
      end
      if (got.py !== want.py) begin
        $error("cross_y expected %0d actual %0d", $signed(want.py), $signed(got.py));
        errors++;
      end
      if (got.ang !== want.ang) begin
        $error("corner_angle expected %0d actual %0d", want.ang, got.ang);
        errors++;
      end
    endfunction
  endclass

  localparam int PIPE_LAT = 41;
  localparam int STALL_LIMIT = 2000;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [IN_W-1:0] pins [8];
  logic is_corner;
  logic [XY_W-1:0] cross_x, cross_y;
  logic [ANG_W-1:0] corner_angle;
  logic min_length_we;
  logic [CFG_W-1:0] min_length_wdata;

  corner_board board;
  bit quiet_tail;     // no idling on either side near the end
  int idle_cycles = 0;

  segment_corner_intersection u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .first_x_start(pins[0]), .first_y_start(pins[1]),
    .first_x_end(pins[2]), .first_y_end(pins[3]),
    .second_x_start(pins[4]), .second_y_start(pins[5]),
    .second_x_end(pins[6]), .second_y_end(pins[7]),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_corner(is_corner), .cross_x(cross_x), .cross_y(cross_y),
    .corner_angle(corner_angle),
    .min_length_we(min_length_we), .min_length_wdata(min_length_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        board.check_result('{is_corner, cross_x, cross_y, corner_angle});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog on cycles with no progress on either channel
  always @(posedge clk) begin
    if (idle_cycles > STALL_LIMIT) begin
      $display("timeout after %0d cycles without progress", idle_cycles);
      $display("segment_corner_intersection_test failed");
      $finish;
    end
  end

  // result side stalls in bursts of random length
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 9);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(negedge clk);
    end
  end

  // present one pair and hold it until accepted; valid drops only for a random gap before an item
  task automatic send_pair(seg_pair_t p);
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    for (int i = 0; i < 8; i++) pins[i] <= p.c[i];
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(p);
    @(negedge clk);
  endtask

  // drain expected results, then let the pipe settle before a write
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  task automatic write_min_length(logic [CFG_W-1:0] v);
    min_length_wdata <= v;
    min_length_we <= 1'b1;
    @(negedge clk);
    min_length_we <= 1'b0;
    board.min_len = v;
  endtask

  function automatic seg_pair_t make_pair(int a, int b, int c, int d,
                                          int e, int f, int g, int h);
    seg_pair_t p;
    p.c[0] = IN_W'(a); p.c[1] = IN_W'(b); p.c[2] = IN_W'(c); p.c[3] = IN_W'(d);
    p.c[4] = IN_W'(e); p.c[5] = IN_W'(f); p.c[6] = IN_W'(g); p.c[7] = IN_W'(h);
    return p;
  endfunction

  // mostly well-formed corners: two segments sharing an endpoint region,
  // sometimes with a crossing (t-junction), sometimes fully random noise
  function automatic seg_pair_t random_pair(int span);
    seg_pair_t p;
    int cx, cy, kind;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      for (int i = 0; i < 8; i++) p.c[i] = IN_W'($urandom);
      return p;
    end
    cx = $urandom_range(0, 4095);
    cy = $urandom_range(0, 4095);
    p.c[0] = IN_W'(cx); p.c[1] = IN_W'(cy);
    p.c[4] = (kind < 7) ? IN_W'(cx + $urandom_range(0, 6) - 3) : IN_W'($urandom_range(0, 4095));
    p.c[5] = (kind < 7) ? IN_W'(cy + $urandom_range(0, 6) - 3) : IN_W'($urandom_range(0, 4095));
    p.c[2] = IN_W'(cx + $urandom_range(0, 2 * span) - span);
    p.c[3] = IN_W'(cy + $urandom_range(0, 2 * span) - span);
    p.c[6] = IN_W'(cx + $urandom_range(0, 2 * span) - span);
    p.c[7] = IN_W'(cy + $urandom_range(0, 2 * span) - span);
    // sometimes swap endpoints so ordering is exercised on both segments
    if ($urandom_range(0, 1)) begin
      p.c = '{p.c[2], p.c[3], p.c[0], p.c[1], p.c[4], p.c[5], p.c[6], p.c[7]};
    end
    if ($urandom_range(0, 1)) begin
      p.c = '{p.c[0], p.c[1], p.c[2], p.c[3], p.c[6], p.c[7], p.c[4], p.c[5]};
    end
    // occasionally make one segment vertical
    if ($urandom_range(0, 15) == 0) p.c[2] = p.c[0];
    if ($urandom_range(0, 15) == 0) p.c[6] = p.c[4];
    return p;
  endfunction

  logic [CFG_W-1:0] settings [5] = '{13'd0, 13'd5793, 13'd1, 13'd40, 13'd300};

  initial begin
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    for (int i = 0; i < 8; i++) pins[i] = '0;
    min_length_we = 1'b0;
    min_length_wdata = '0;
    quiet_tail = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset threshold of 300 in force
    send_pair(make_pair(0, 0, 4095, 0, 0, 0, 0, 4095));          // right angle at origin
    send_pair(make_pair(4095, 4095, 0, 4095, 4095, 0, 4095, 4095)); // swapped, corner at max
    send_pair(make_pair(0, 0, 100, 100, 0, 100, 100, 0));          // too short
    send_pair(make_pair(0, 0, 4095, 4095, 0, 10, 4095, 4105 % 4096)); // second end y wraps to 9: shallow crossing
    send_pair(make_pair(0, 0, 4000, 0, 0, 500, 4000, 500));        // parallel
    send_pair(make_pair(0, 2000, 4000, 2000, 2000, 0, 2000, 4000)); // crossing: t-junction
    send_pair(make_pair(0, 4095, 4095, 0, 0, 0, 0, 4095));         // falling segment
    send_pair(make_pair(4095, 0, 0, 4095, 4095, 4095, 0, 0));      // both swapped
    send_pair(make_pair(100, 100, 4000, 101, 4000, 4000, 3999, 0)); // far intersection
    send_pair(make_pair(0, 0, 4095, 1, 0, 1, 4095, 0));            // shallow crossing
    send_pair(make_pair(2048, 0, 2048, 4095, 2048, 0, 2048, 4095)); // vertical, equal x
    send_pair(make_pair(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095)); // all ones
    drain();

    // directed: degenerate segment with zero threshold
    write_min_length(13'd0);
    send_pair(make_pair(5, 5, 5, 5, 0, 0, 100, 100));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(0, 0, 1, 4095, 0, 4095, 1, 0));            // steep crossing
    send_pair(make_pair(0, 0, 4095, 2, 0, 0, 4095, 1));            // nearly parallel
    drain();
    write_min_length(13'd5793);
    send_pair(make_pair(0, 0, 4095, 4095, 0, 4095, 4095, 0));      // longest, still short
    drain();

    // random phases across threshold settings
    for (int ph = 0; ph < 5; ph++) begin
      write_min_length(settings[ph]);
      for (int k = 0; k < 250; k++) begin
        if (ph == 4 && k == 180) quiet_tail = 1'b1;
        send_pair(random_pair(settings[ph] > 1000 ? 2047 : $urandom_range(8, 1500)));
      end
      drain();
    end

    $display("checked %0d results, %0d of them corners, over five threshold values",
             board.checked, board.corners_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("segment_corner_intersection_test passed");
    end else begin
      $display("segment_corner_intersection_test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
